/* sv/rrh_pkg.sv */
package rrh_pkg;

  localparam int unsigned SpaceK24 = 838436;
  localparam int unsigned TimeK32  = 643918489;
  localparam int unsigned PolyA    = 25736;
  localparam int unsigned PolyB    = 10512;
  localparam int unsigned PolyC    = 1160;

  localparam int MaxGridSide = 256;

  localparam int DistW  = 34;
  localparam int RootW  = 17;
  localparam int SqrtSteps = 17;

  localparam logic [1:0] RegGridColumns = 2'd0;
  localparam logic [1:0] RegGridRows    = 2'd1;
  localparam logic [1:0] RegFrameStep   = 2'd2;

  typedef struct packed {
    logic [DistW-1:0] rem;
    logic [RootW-1:0] root;
  } sqrt_state_t;

endpackage

/* sv/rrh_sqrt.sv */
module rrh_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [rrh_pkg::DistW-1:0]  in_d2,
  input  logic [31:0]                in_tphase,
  output logic                       out_vld,
  output logic [rrh_pkg::RootW-1:0]  out_root,
  output logic [31:0]                out_tphase
);

  localparam int N = rrh_pkg::SqrtSteps;

  logic [N:0]                 vld_r;
  rrh_pkg::sqrt_state_t       st_r   [N+1];
  logic [rrh_pkg::DistW-1:0]  rad_r  [N+1];
  logic [31:0]                tph_r  [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    st_r[0].rem  <= '0;
    st_r[0].root <= '0;
    rad_r[0]     <= in_d2;
    tph_r[0]     <= in_tphase;
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [rrh_pkg::DistW+1:0] trial;
    logic [rrh_pkg::DistW+1:0] acc;
    always_comb begin
      acc   = {st_r[g].rem, rad_r[g][rrh_pkg::DistW-1 -: 2]};
      trial = {{(rrh_pkg::DistW-rrh_pkg::RootW){1'b0}}, st_r[g].root, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      if (acc >= trial) begin
        st_r[g+1].rem  <= rrh_pkg::DistW'(acc - trial);
        st_r[g+1].root <= {st_r[g].root[rrh_pkg::RootW-2:0], 1'b1};
      end else begin
        st_r[g+1].rem  <= rrh_pkg::DistW'(acc);
        st_r[g+1].root <= {st_r[g].root[rrh_pkg::RootW-2:0], 1'b0};
      end
      rad_r[g+1] <= {rad_r[g][rrh_pkg::DistW-3:0], 2'b00};
      tph_r[g+1] <= tph_r[g];
    end
  end

  assign out_vld    = vld_r[N];
  assign out_root   = st_r[N].root;
  assign out_tphase = tph_r[N];

endmodule

/* sv/rrh_sine.sv */
module rrh_sine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [rrh_pkg::RootW-1:0] in_root,
  input  logic [31:0]               in_tphase,
  output logic                      out_vld,
  output logic [15:0]               out_height
);

  logic [6:0]  vld_r;
  logic [31:0] ph_r;
  logic [31:0] sp_r;
  logic [31:0] tp_r;
  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic [14:0] x1_r, x2a_r, x3_r, x4_r;
  logic [14:0] sq_r, sq3_r;
  logic [14:0] t1_r;
  logic [14:0] t2_r;
  logic [15:0] h_r;

  logic [15:0] p;
  logic [14:0] xs;
  logic [29:0] xx;
  logic [25:0] ct;
  logic [29:0] bt;
  logic [29:0] at;
  logic [15:0] s14;
  logic [13:0] s12r;
  logic [12:0] s12;

  always_comb begin
    p   = ph_r[31:16];
    xs  = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    xx  = x1_r * x1_r;
    ct  = 26'(rrh_pkg::PolyC) * {11'd0, sq_r};
    bt  = 30'(15'(rrh_pkg::PolyB) - t1_r) * {15'd0, sq3_r};
    at  = 30'(x4_r) * 30'(15'(rrh_pkg::PolyA) - t2_r);
    s14 = at[29:14];
    s12r = 14'((s14 + 16'd2) >> 2);
    s12 = (s12r > 14'd4096) ? 13'd4096 : s12r[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
    sp_r  <= 32'(in_root) * rrh_pkg::SpaceK24;
    tp_r  <= in_tphase;
    ph_r  <= sp_r + tp_r;
    q1_r  <= p[15:14];
    x1_r  <= xs;
    q2_r  <= q1_r;
    x2a_r <= x1_r;
    sq_r  <= 15'(xx >> 14);
    q3_r  <= q2_r;
    x3_r  <= x2a_r;
    sq3_r <= sq_r;
    t1_r  <= 15'(ct >> 14);
    q4_r  <= q3_r;
    x4_r  <= x3_r;
    t2_r  <= 15'(bt >> 14);
    h_r   <= q4_r[1] ? 16'(16'd32768 - 16'(s12)) : 16'(16'd32768 + 16'(s12));
  end

  assign out_vld    = vld_r[6];
  assign out_height = h_r;

endmodule

/* sv/radial_ripple_height_top.sv */
// Channel  | Ports                                   | Direction
// input    | start, busy, in_column, in_row          | in (busy out)
// result   | out_valid, out_height_q12               | out
// config   | psel penable pwrite paddr pwdata prdata pready | APB
// One vertex is accepted per cycle; busy stays low after reset.
// The pipeline runs through the setup registers, the square root (an input
// register and seventeen digit stages) and the phase and sine stages.
// Synchronous reset clears all valid bits and sets the config registers (grid sides 256, frame step 0).
// The receiver cannot stall, so the pipeline never holds.
module radial_ripple_height_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_column,
  input  logic [7:0]  in_row,
  output logic        out_valid,
  output logic [15:0] out_height_q12,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  cfg_grid_columns_r;
  logic [8:0]  cfg_grid_rows_r;
  logic [15:0] cfg_frame_step_r;
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_grid_columns_r <= 9'd256;
      cfg_grid_rows_r    <= 9'd256;
      cfg_frame_step_r   <= '0;
    end else if (wr) begin
      unique case (idx)
        rrh_pkg::RegGridColumns: cfg_grid_columns_r <= pwdata[8:0];
        rrh_pkg::RegGridRows:    cfg_grid_rows_r    <= pwdata[8:0];
        rrh_pkg::RegFrameStep:   cfg_frame_step_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rrh_pkg::RegGridColumns: prdata = {23'd0, cfg_grid_columns_r};
      rrh_pkg::RegGridRows:    prdata = {23'd0, cfg_grid_rows_r};
      rrh_pkg::RegFrameStep:   prdata = {16'd0, cfg_frame_step_r};
      default:                 prdata = '0;
    endcase
  end

  logic        s0_vld_r, s1_vld_r;
  logic [9:0]  dx_r;
  logic [7:0]  row_r;
  logic [31:0] tph_r, tph1_r;
  logic [17:0] d2_r;
  logic [8:0]  gcs;
  logic [9:0]  dxa;
  logic [19:0] dxx;
  logic [15:0] rr;

  assign gcs = (cfg_grid_columns_r > 9'(rrh_pkg::MaxGridSide)) ? 9'(rrh_pkg::MaxGridSide)
                                                               : cfg_grid_columns_r;
  assign dxa = dx_r[9] ? 10'(-dx_r) : dx_r;
  assign dxx = dxa * dxa;
  assign rr  = row_r * row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
      s1_vld_r <= s0_vld_r;
    end
    dx_r   <= 10'({1'b0, gcs} - {2'b00, in_column});
    row_r  <= in_row;
    tph_r  <= 32'(cfg_frame_step_r) * rrh_pkg::TimeK32;
    d2_r   <= 18'(dxx + 20'(rr));
    tph1_r <= tph_r;
  end

  logic                      sq_vld;
  logic [rrh_pkg::RootW-1:0] sq_root;
  logic [31:0]               sq_tph;

  rrh_sqrt u_sqrt (
    .clk, .rst_n,
    .in_vld(s1_vld_r),
    .in_d2({d2_r, 16'd0}),
    .in_tphase(tph1_r),
    .out_vld(sq_vld),
    .out_root(sq_root),
    .out_tphase(sq_tph)
  );

  rrh_sine u_sine (
    .clk, .rst_n,
    .in_vld(sq_vld),
    .in_root(sq_root),
    .in_tphase(sq_tph),
    .out_vld(out_valid),
    .out_height(out_height_q12)
  );

`ifndef SYNTHESIS
  a_no_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(start, 2)) else $error("valid without start");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_height_q12 >= 16'd28672 && out_height_q12 <= 16'd36864))
    else $error("height out of range");
`endif

endmodule

/* tb/radial_ripple_height_top_test.sv */
`timescale 1ns / 1ps

module radial_ripple_height_top_test;

  localparam int Latency = 27;
  localparam int StallLimit = 2000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_column;
  logic [7:0]  in_row;
  logic        out_valid;
  logic [15:0] out_height_q12;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  radial_ripple_height_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_column(in_column),
    .in_row(in_row),
    .out_valid(out_valid),
    .out_height_q12(out_height_q12),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  typedef struct {
    logic [7:0]  column;
    logic [7:0]  row;
    logic        known;
    logic [15:0] height;
  } vertex_row_t;

  logic [8:0]  grid_columns_q;
  logic [8:0]  grid_rows_q;
  logic [15:0] frame_step_q;
  logic [15:0] heights_pending[$];
  int          mismatches;
  int          idle_cycles;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [15:0] ripple_height(logic [7:0] column, logic [7:0] row);
    longint      gc;
    longint      dx;
    logic [63:0] d2;
    logic [63:0] dist_q8;
    logic [63:0] phase;
    logic [15:0] p;
    logic [1:0]  quad;
    logic [31:0] x;
    logic [31:0] x2;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s14;
    logic [31:0] s12;
    gc = grid_columns_q;
    if (gc > rrh_pkg::MaxGridSide) gc = rrh_pkg::MaxGridSide;
    dx = gc - longint'(column);
    d2 = 64'(dx * dx) + 64'(row) * 64'(row);
    dist_q8 = 64'(floor_root(d2 << 16));
    phase = (dist_q8 * 64'(rrh_pkg::SpaceK24) + 64'(frame_step_q) * 64'(rrh_pkg::TimeK32))
            & 64'hFFFF_FFFF;
    p = phase[31:16];
    quad = p[15:14];
    x = {18'd0, p[13:0]};
    if (quad[0]) x = 32'd16384 - x;
    x2 = (x * x) >> 14;
    t1 = (rrh_pkg::PolyC * x2) >> 14;
    t2 = ((rrh_pkg::PolyB - t1) * x2) >> 14;
    s14 = (x * (rrh_pkg::PolyA - t2)) >> 14;
    s12 = (s14 + 2) >> 2;
    if (s12 > 4096) s12 = 4096;
    return (quad < 2) ? 16'(32768 + s12) : 16'(32768 - s12);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (heights_pending.size() == 0) begin
        report_mismatch("unexpected height_q12", out_height_q12, 16'd0);
      end else begin
        logic [15:0] want;
        want = heights_pending.pop_front();
        if (out_height_q12 !== want) report_mismatch("height_q12", out_height_q12, want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic reg_write(logic [1:0] index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      rrh_pkg::RegGridColumns: grid_columns_q = value[8:0];
      rrh_pkg::RegGridRows:    grid_rows_q = value[8:0];
      rrh_pkg::RegFrameStep:   frame_step_q = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_vertex(logic [7:0] column, logic [7:0] row, logic known,
                             logic [15:0] height);
    int gap;
    logic [15:0] want;
    gap = gap_length();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_column <= column;
    in_row <= row;
    do @(posedge clk); while (busy);
    want = ripple_height(column, row);
    if (known && want !== height) report_mismatch("predictor table", want, height);
    heights_pending.insert(heights_pending.size(), want);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (heights_pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  vertex_row_t directed_rows[] = '{
    '{8'd0,   8'd0,   1'b1, 16'd28823},
    '{8'd255, 8'd255, 1'b0, 16'd0},
    '{8'd255, 8'd0,   1'b0, 16'd0},
    '{8'd0,   8'd255, 1'b0, 16'd0},
    '{8'd128, 8'd64,  1'b0, 16'd0},
    '{8'd170, 8'd85,  1'b0, 16'd0},
    '{8'd85,  8'd170, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b0, 16'd0},
    '{8'd200, 8'd17,  1'b0, 16'd0},
    '{8'd37,  8'd199, 1'b0, 16'd0}
  };

  logic [8:0]  col_settings[] = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd1, 9'd100, 9'd257};
  logic [8:0]  row_settings[] = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd7, 9'd255, 9'd128};
  logic [15:0] step_settings[] = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd4321, 16'd12,
                                   16'd40000};

  initial begin
    int phase_items;
    rst_n = 1'b0;
    start = 1'b0;
    in_column = '0;
    in_row = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    grid_columns_q = 9'd256;
    grid_rows_q = 9'd256;
    frame_step_q = 16'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].column, directed_rows[i].row, directed_rows[i].known,
                  directed_rows[i].height);
    end
    drain();

    foreach (col_settings[s]) begin
      reg_write(rrh_pkg::RegGridColumns, {$urandom} & 32'hFFFF_FE00 | 32'(col_settings[s]));
      reg_write(rrh_pkg::RegGridRows, 32'(row_settings[s]));
      reg_write(rrh_pkg::RegFrameStep, {16'(~s), step_settings[s]});
      send_vertex(8'd0, 8'd0, 1'b0, 16'd0);
      send_vertex(8'd255, 8'd255, 1'b0, 16'd0);
      phase_items = 220;
      for (int n = 0; n < phase_items; n++) begin
        logic [7:0] c;
        logic [7:0] r;
        if ($urandom_range(0, 3) != 0 && grid_columns_q > 1 && grid_rows_q > 1) begin
          c = 8'($urandom_range(0, (grid_columns_q > 256 ? 256 : grid_columns_q) - 1));
          r = 8'($urandom_range(0, (grid_rows_q > 256 ? 256 : grid_rows_q) - 1));
        end else begin
          c = 8'($urandom);
          r = 8'($urandom);
        end
        send_vertex(c, r, 1'b0, 16'd0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
